@@ src/rma_pkg.sv @@
// ----------------------------------------------------------------------------
// rma_pkg: shared types and constants of the receive metric averager
// Table geometry, operation and status codes, dB conversion constants.
// ----------------------------------------------------------------------------
`default_nettype none
package rma_pkg;
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int REM_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [1:0] OP_UPDATE    = 2'd0;
	localparam logic [1:0] OP_CLEAR_ANT = 2'd1;
	localparam logic [1:0] OP_CLEAR_ALL = 2'd2;
	localparam logic [1:0] OP_NONE      = 2'd3;

	localparam logic [1:0] STAT_UPDATED = 2'd0;
	localparam logic [1:0] STAT_NEW     = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_CLEAR   = 2'd3;

	localparam logic CFG_COMBINE_ANT  = 1'b0;
	localparam logic CFG_COMBINE_FREQ = 1'b1;

	localparam logic signed [14:0] DB_MIN  = -15'sd12800;
	localparam logic signed [14:0] DB_MAX  = 15'sd12800;
	localparam logic [24:0]        DB_COEF = 25'd12626113;

	typedef struct packed {
		logic [15:0] source;
		logic [15:0] antenna;
		logic [47:0] frequency;
		logic [31:0] count;
		logic [63:0] avg_rx;
		logic [63:0] avg_noise;
		logic [63:0] avg_sinr;
		logic [63:0] avg_inr;
	} entry_t;
endpackage
`default_nettype wire

@@ src/rma_req_if.sv @@
// ----------------------------------------------------------------------------
// rma_req_if: request channel of the receive metric averager
// One operation with its key and sample values.
// ----------------------------------------------------------------------------
`default_nettype none
interface rma_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] source_id;
	logic [15:0] antenna_id;
	logic [47:0] frequency_hz;
	logic [63:0] rx_power_mw;
	logic [63:0] noise_floor_mw;
	logic [63:0] sensitivity_mw;
	modport source(output valid, operation, source_id, antenna_id, frequency_hz,
		rx_power_mw, noise_floor_mw, sensitivity_mw, input ready);
	modport sink(input valid, operation, source_id, antenna_id, frequency_hz,
		rx_power_mw, noise_floor_mw, sensitivity_mw, output ready);
endinterface
`default_nettype wire

@@ src/rma_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rma_rsp_if: response channel of the receive metric averager
// Status, sample count, four averages in 1/64 dB and the clear count.
// ----------------------------------------------------------------------------
`default_nettype none
interface rma_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [31:0]        sample_count;
	logic signed [14:0] avg_rx_power_db;
	logic signed [14:0] avg_noise_floor_db;
	logic signed [14:0] avg_sinr_db;
	logic signed [14:0] avg_inr_db;
	logic [6:0]         entries_removed;
	modport source(output valid, status, sample_count, avg_rx_power_db,
		avg_noise_floor_db, avg_sinr_db, avg_inr_db, entries_removed, input ready);
	modport sink(input valid, status, sample_count, avg_rx_power_db,
		avg_noise_floor_db, avg_sinr_db, avg_inr_db, entries_removed, output ready);
endinterface
`default_nettype wire

@@ src/rma_cfg_if.sv @@
// ----------------------------------------------------------------------------
// rma_cfg_if: configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none
interface rma_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/rma_div.sv @@
// ----------------------------------------------------------------------------
// rma_div: 128 by 64 bit restoring divider, one quotient bit per cycle
// Quotient saturates to all ones when it does not fit in 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module rma_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] num,
	input  wire logic [63:0]  den,
	output logic              done,
	output logic [63:0]       quo
);
	logic         busy_q;
	logic [6:0]   cnt_q;
	logic         done_q;
	logic [127:0] n_q;
	logic [63:0]  d_q;
	logic [63:0]  r_q;
	logic [63:0]  q_q;
	logic         sat_q;
	logic [64:0]  rsh;
	logic [64:0]  diff;
	logic         ge;

	assign rsh  = {r_q, n_q[127]};
	assign ge   = rsh >= {1'b0, d_q};
	assign diff = rsh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			n_q <= {n_q[126:0], 1'b0};
			r_q <= ge ? diff[63:0] : rsh[63:0];
			q_q <= {q_q[62:0], ge};
			// upper half of the quotient must stay zero
			if (ge && !cnt_q[6])
				sat_q <= 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = sat_q ? '1 : q_q;
endmodule
`default_nettype wire

@@ src/rma_log.sv @@
// ----------------------------------------------------------------------------
// rma_log: fixed-point value to 1/64 dB
// Leading-one search a bit a cycle, 16 squaring steps, scale and round.
// ----------------------------------------------------------------------------
`default_nettype none
module rma_log (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] val,
	input  wire logic        frac48,
	output logic             done,
	output logic signed [14:0] db
);
	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_NORM = 3'd1;
	localparam logic [2:0] L_SQ   = 3'd2;
	localparam logic [2:0] L_MUL  = 3'd3;
	localparam logic [2:0] L_RND  = 3'd4;

	logic [2:0]         st_q;
	logic               done_q;
	logic [63:0]        v_q;
	logic [5:0]         e_q;
	logic [31:0]        y_q;
	logic [15:0]        frac_q;
	logic [3:0]         k_q;
	logic               f48_q;
	logic signed [48:0] p_q;
	logic signed [14:0] db_q;

	logic [63:0]        sq;
	logic signed [7:0]  ef;
	logic signed [48:0] lq_ext;
	logic signed [48:0] coef_ext;
	logic signed [48:0] t;
	logic signed [16:0] r;

	assign sq       = 64'(y_q) * 64'(y_q);
	assign ef       = $signed({2'b00, e_q}) - (f48_q ? 8'sd48 : 8'sd32);
	assign lq_ext   = 49'($signed({ef, frac_q}));
	assign coef_ext = $signed({24'd0, rma_pkg::DB_COEF});
	assign t        = p_q + 49'sd2147483648;
	assign r        = t[48:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				L_IDLE: begin
					if (start) begin
						if (val == 64'd0) begin
							db_q   <= rma_pkg::DB_MIN;
							done_q <= 1'b1;
						end else begin
							v_q   <= val;
							e_q   <= 6'd63;
							f48_q <= frac48;
							st_q  <= L_NORM;
						end
					end
				end
				L_NORM: begin
					if (v_q[63]) begin
						y_q    <= v_q[63:32];
						k_q    <= '0;
						frac_q <= '0;
						st_q   <= L_SQ;
					end else begin
						v_q <= {v_q[62:0], 1'b0};
						e_q <= e_q - 6'd1;
					end
				end
				L_SQ: begin
					// square the Q1.31 mantissa, renormalize into [1,2)
					if (sq[63])
						y_q <= sq[63:32];
					else
						y_q <= sq[62:31];
					frac_q <= {frac_q[14:0], sq[63]};
					k_q    <= k_q + 4'd1;
					if (k_q == 4'd15)
						st_q <= L_MUL;
				end
				L_MUL: begin
					p_q  <= lq_ext * coef_ext;
					st_q <= L_RND;
				end
				L_RND: begin
					if (r < 17'(rma_pkg::DB_MIN))
						db_q <= rma_pkg::DB_MIN;
					else if (r > 17'(rma_pkg::DB_MAX))
						db_q <= rma_pkg::DB_MAX;
					else
						db_q <= r[14:0];
					done_q <= 1'b1;
					st_q   <= L_IDLE;
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign db   = db_q;
endmodule
`default_nettype wire

@@ src/rf_receive_metric_averager.sv @@
// ----------------------------------------------------------------------------
// rf_receive_metric_averager: keyed table of running receive averages
// Per (source, antenna, frequency) averages of power, noise, SINR and INR.
// ----------------------------------------------------------------------------
// Usage:
//  - req carries one request: update a sample, clear one antenna, clear all.
//    Operation code 3 is swallowed with no response.
//  - rsp returns one response per request: status, sample count, four
//    averages in 1/64 dB and the number of entries removed by a clear.
//  - cfg writes combine_antennas (index 0) or combine_frequencies (index 1);
//    it is always ready. Write only while no request is in flight.
// Timing: one request at a time; req.ready is high only while idle.
//  - table scan: each entry is read (ST_RD) and then compared (ST_CMP).
//  - update: scan, then two running means and up to two ratios, each one
//    pass of the shared 128-step restoring divider, then four dB
//    conversions. A clear or a full table skips the divider and the dB
//    conversions.
// Reset clears the valid bits and the control registers; the entry store
// itself is not cleared, a free entry is written in full on allocation.
// A stalled rsp holds its result; the block finishes the next request and
// waits for the output register to drain before going idle again.
// ----------------------------------------------------------------------------
`default_nettype none
module rf_receive_metric_averager (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rma_req_if.sink     req,
	rma_rsp_if.source   rsp,
	rma_cfg_if.sink     cfg
);
	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_RD     = 5'd1;
	localparam logic [4:0] ST_CMP    = 5'd2;
	localparam logic [4:0] ST_DECIDE = 5'd3;
	localparam logic [4:0] ST_M0     = 5'd4;
	localparam logic [4:0] ST_M1     = 5'd5;
	localparam logic [4:0] ST_SUM    = 5'd6;
	localparam logic [4:0] ST_DWAIT  = 5'd7;
	localparam logic [4:0] ST_SINR   = 5'd8;
	localparam logic [4:0] ST_SWAIT  = 5'd9;
	localparam logic [4:0] ST_INR    = 5'd10;
	localparam logic [4:0] ST_IWAIT  = 5'd11;
	localparam logic [4:0] ST_CNT    = 5'd12;
	localparam logic [4:0] ST_WR     = 5'd13;
	localparam logic [4:0] ST_LOG    = 5'd14;
	localparam logic [4:0] ST_LWAIT  = 5'd15;
	localparam logic [4:0] ST_OUT    = 5'd16;

	localparam int IW = rma_pkg::IDX_W;

	// configuration
	logic comb_ant_q;
	logic comb_freq_q;

	// request latch
	logic [1:0]  op_q;
	logic [15:0] src_q;
	logic [15:0] ant_q;
	logic [47:0] freq_q;
	logic [63:0] rx_in_q;
	logic [63:0] noise_in_q;
	logic [63:0] sens_q;

	// sequencer
	logic [4:0]                   state_q;
	logic [IW-1:0]                idx_q;
	logic [IW-1:0]                slot_q;
	logic [IW-1:0]                free_idx_q;
	logic                         found_q;
	logic                         free_q;
	logic [rma_pkg::REM_W-1:0]    removed_q;
	logic [1:0]                   status_q;
	logic                         sel_q;
	logic [1:0]                   lsel_q;

	// table
	logic [rma_pkg::TABLE_ENTRIES-1:0] valid_q;
	rma_pkg::entry_t entry_mem [rma_pkg::TABLE_ENTRIES];
	rma_pkg::entry_t rd_q;
	rma_pkg::entry_t wr_entry;
	logic            mem_we;

	// working copy of the entry
	logic [31:0] w_count_q;
	logic [63:0] w_rx_q;
	logic [63:0] w_noise_q;
	logic [63:0] w_sinr_q;
	logic [63:0] w_inr_q;
	logic signed [14:0] db_q [4];

	// running mean product
	logic [63:0]  prod_lo_q;
	logic [63:0]  prod_hi_q;
	logic [63:0]  mul_a;
	logic [63:0]  mul_x;
	logic [95:0]  mean_num;

	// shared units
	logic         div_start;
	logic [127:0] div_num;
	logic [63:0]  div_den;
	logic         div_done;
	logic [63:0]  div_quo;
	logic         log_start;
	logic [63:0]  log_val;
	logic         log_done;
	logic signed [14:0] log_db;

	// output register
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [31:0]        out_count_q;
	logic signed [14:0] out_db_q [4];
	logic [6:0]         out_removed_q;

	logic key_match;
	logic clear_hit;
	logic last_idx;
	logic out_free;
	logic out_load;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign out_load  = (state_q == ST_OUT) && out_free;

	assign key_match = (rd_q.source == src_q) && (rd_q.antenna == ant_q) &&
		(rd_q.frequency == freq_q);
	assign clear_hit = (op_q == rma_pkg::OP_CLEAR_ALL) || (rd_q.antenna == ant_q);
	assign last_idx  = (idx_q == IW'(rma_pkg::TABLE_ENTRIES - 1));

	assign mul_a    = sel_q ? w_noise_q : w_rx_q;
	assign mul_x    = sel_q ? noise_in_q : rx_in_q;
	assign mean_num = {prod_hi_q, 32'd0} + {32'd0, prod_lo_q} + {32'd0, mul_x};

	always_comb begin
		div_start = 1'b0;
		div_num   = {32'd0, mean_num};
		div_den   = {31'd0, ({1'b0, w_count_q} + 33'd1)};
		unique case (state_q)
			ST_SUM: div_start = 1'b1;
			ST_SINR: begin
				div_start = (w_noise_q != 64'd0);
				div_num   = {32'd0, w_rx_q, 32'd0};
				div_den   = w_noise_q;
			end
			ST_INR: begin
				div_start = (sens_q != 64'd0);
				div_num   = {32'd0, w_noise_q, 32'd0};
				div_den   = sens_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	always_comb begin
		unique case (lsel_q)
			2'd0:    log_val = w_rx_q;
			2'd1:    log_val = w_noise_q;
			2'd2:    log_val = w_sinr_q;
			default: log_val = w_inr_q;
		endcase
	end
	assign log_start = (state_q == ST_LOG);

	rma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	rma_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.val    (log_val),
		.frac48 (!lsel_q[1]),
		.done   (log_done),
		.db     (log_db)
	);

	// entry store: one registered read, one write
	assign mem_we   = (state_q == ST_WR);
	assign wr_entry = '{source: src_q, antenna: ant_q, frequency: freq_q,
		count: w_count_q, avg_rx: w_rx_q, avg_noise: w_noise_q,
		avg_sinr: w_sinr_q, avg_inr: w_inr_q};

	always_ff @(posedge clk) begin
		if (mem_we)
			entry_mem[slot_q] <= wr_entry;
		rd_q <= entry_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comb_ant_q  <= 1'b0;
			comb_freq_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rma_pkg::CFG_COMBINE_ANT:  comb_ant_q  <= cfg.data;
				rma_pkg::CFG_COMBINE_FREQ: comb_freq_q <= cfg.data;
				default:                   comb_ant_q  <= comb_ant_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			removed_q   <= '0;
			sel_q       <= 1'b0;
			lsel_q      <= '0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.operation != rma_pkg::OP_NONE) begin
						op_q       <= req.operation;
						src_q      <= req.source_id;
						ant_q      <= comb_ant_q ? 16'd0 : req.antenna_id;
						freq_q     <= comb_freq_q ? 48'd0 : req.frequency_hz;
						rx_in_q    <= req.rx_power_mw;
						noise_in_q <= req.noise_floor_mw;
						sens_q     <= req.sensitivity_mw;
						idx_q      <= '0;
						found_q    <= 1'b0;
						free_q     <= 1'b0;
						removed_q  <= '0;
						state_q    <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					if (valid_q[idx_q]) begin
						if (op_q != rma_pkg::OP_UPDATE) begin
							if (clear_hit) begin
								valid_q[idx_q] <= 1'b0;
								removed_q      <= removed_q + 1'b1;
							end
						end else if (!found_q && key_match) begin
							found_q   <= 1'b1;
							slot_q    <= idx_q;
							w_count_q <= rd_q.count;
							w_rx_q    <= rd_q.avg_rx;
							w_noise_q <= rd_q.avg_noise;
							w_sinr_q  <= rd_q.avg_sinr;
							w_inr_q   <= rd_q.avg_inr;
						end
					end else if (!free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (last_idx)
						state_q <= ST_DECIDE;
					else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_DECIDE: begin
					sel_q <= 1'b0;
					for (int i = 0; i < 4; i++)
						db_q[i] <= '0;
					priority if (op_q != rma_pkg::OP_UPDATE) begin
						status_q  <= rma_pkg::STAT_CLEAR;
						w_count_q <= '0;
						state_q   <= ST_OUT;
					end else if (found_q) begin
						status_q <= rma_pkg::STAT_UPDATED;
						state_q  <= ST_M0;
					end else if (free_q) begin
						status_q  <= rma_pkg::STAT_NEW;
						slot_q    <= free_idx_q;
						w_count_q <= '0;
						w_rx_q    <= '0;
						w_noise_q <= '0;
						w_sinr_q  <= '0;
						w_inr_q   <= '0;
						state_q   <= ST_M0;
					end else begin
						status_q  <= rma_pkg::STAT_FULL;
						w_count_q <= '0;
						state_q   <= ST_OUT;
					end
				end
				ST_M0: begin
					prod_lo_q <= 64'(mul_a[31:0]) * 64'(w_count_q);
					state_q   <= ST_M1;
				end
				ST_M1: begin
					prod_hi_q <= 64'(mul_a[63:32]) * 64'(w_count_q);
					state_q   <= ST_SUM;
				end
				ST_SUM: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						if (sel_q) begin
							w_noise_q <= div_quo;
							state_q   <= ST_SINR;
						end else begin
							w_rx_q  <= div_quo;
							sel_q   <= 1'b1;
							state_q <= ST_M0;
						end
					end
				end
				ST_SINR: state_q <= (w_noise_q != 64'd0) ? ST_SWAIT : ST_INR;
				ST_SWAIT: begin
					if (div_done) begin
						w_sinr_q <= div_quo;
						state_q  <= ST_INR;
					end
				end
				ST_INR: state_q <= (sens_q != 64'd0) ? ST_IWAIT : ST_CNT;
				ST_IWAIT: begin
					if (div_done) begin
						w_inr_q <= div_quo;
						state_q <= ST_CNT;
					end
				end
				ST_CNT: begin
					// saturating count
					if (w_count_q != '1)
						w_count_q <= w_count_q + 32'd1;
					state_q <= ST_WR;
				end
				ST_WR: begin
					valid_q[slot_q] <= 1'b1;
					lsel_q          <= '0;
					state_q         <= ST_LOG;
				end
				ST_LOG: state_q <= ST_LWAIT;
				ST_LWAIT: begin
					if (log_done) begin
						db_q[lsel_q] <= log_db;
						lsel_q       <= lsel_q + 2'd1;
						state_q      <= (lsel_q == 2'd3) ? ST_OUT : ST_LOG;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_status_q  <= status_q;
						out_count_q   <= w_count_q;
						out_removed_q <= 7'(removed_q);
						for (int i = 0; i < 4; i++)
							out_db_q[i] <= db_q[i];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.status             = out_status_q;
	assign rsp.sample_count       = out_count_q;
	assign rsp.avg_rx_power_db    = out_db_q[0];
	assign rsp.avg_noise_floor_db = out_db_q[1];
	assign rsp.avg_sinr_db        = out_db_q[2];
	assign rsp.avg_inr_db         = out_db_q[3];
	assign rsp.entries_removed    = out_removed_q;

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> rsp.valid)
		else $error("finished result not presented");
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == rma_pkg::STAT_FULL) |-> rsp.sample_count == 32'd0)
		else $error("dropped update reports a count");
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == rma_pkg::STAT_CLEAR) |-> rsp.sample_count == 32'd0)
		else $error("clear reports a count");
	a_new_one: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == rma_pkg::STAT_NEW) |-> rsp.sample_count == 32'd1)
		else $error("new entry count not one");
	a_upd_removed: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != rma_pkg::STAT_CLEAR) |-> rsp.entries_removed == 7'd0)
		else $error("update reports removed entries");
endmodule
`default_nettype wire

@@ bench/rf_receive_metric_averager_tb.sv @@
// ----------------------------------------------------------------------------
// rf_receive_metric_averager_tb: self-checking bench of the averager
// Drives update and clear requests under bursty traffic and random response
// stalls, predicts every response from its own table model and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rf_receive_metric_averager_tb;
	localparam longint CYCLE_LIMIT = 8000000;
	localparam int     DRAIN_WAIT  = 1500;  // one slow request and then some

	typedef struct {
		logic [1:0]  op;
		logic [15:0] src;
		logic [15:0] ant;
		logic [47:0] freq;
		logic [63:0] rx;
		logic [63:0] nf;
		logic [63:0] sens;
	} request_t;

	typedef struct {
		logic [1:0]         status;
		logic [31:0]        count;
		logic signed [14:0] rx_db;
		logic signed [14:0] nf_db;
		logic signed [14:0] sinr_db;
		logic signed [14:0] inr_db;
		logic [6:0]         removed;
	} response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rma_req_if req ();
	rma_rsp_if rsp ();
	rma_cfg_if cfg ();

	rf_receive_metric_averager uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	always #5 clk = ~clk;

	request_t  pending_q[$];
	response_t expected_q[$];
	int        err_cnt = 0;
	longint    cyc = 0;
	int        phase_no = 0;

	// ---------------------------------------------------------------- model
	logic        mdl_comb_ant, mdl_comb_freq;
	logic        tbl_valid [rma_pkg::TABLE_ENTRIES];
	logic [15:0] tbl_src   [rma_pkg::TABLE_ENTRIES];
	logic [15:0] tbl_ant   [rma_pkg::TABLE_ENTRIES];
	logic [47:0] tbl_freq  [rma_pkg::TABLE_ENTRIES];
	logic [31:0] tbl_count [rma_pkg::TABLE_ENTRIES];
	logic [63:0] tbl_rx    [rma_pkg::TABLE_ENTRIES];
	logic [63:0] tbl_nf    [rma_pkg::TABLE_ENTRIES];
	logic [63:0] tbl_sinr  [rma_pkg::TABLE_ENTRIES];
	logic [63:0] tbl_inr   [rma_pkg::TABLE_ENTRIES];

	// exact mean in 128 bits, saturated to 64
	function automatic logic [63:0] mean_fold(logic [63:0] avg, logic [31:0] n,
			logic [63:0] x);
		logic [127:0] q;
		q = ({64'd0, avg} * {96'd0, n} + {64'd0, x}) / ({96'd0, n} + 128'd1);
		return (q[127:64] != 0) ? '1 : q[63:0];
	endfunction

	// Q32.32 ratio, saturated
	function automatic logic [63:0] ratio_q32(logic [63:0] num, logic [63:0] den);
		logic [127:0] q;
		q = {32'd0, num, 32'd0} / {64'd0, den};
		return (q[127:64] != 0) ? '1 : q[63:0];
	endfunction

	// log2 by mantissa squaring, scaled to 1/64 dB, rounded and clamped
	function automatic logic signed [14:0] db_of(logic [63:0] v, int fbits);
		int          e;
		logic [63:0] y;
		logic [15:0] frac;
		longint      lq, r;
		if (v == 0) return rma_pkg::DB_MIN;
		e = 63;
		while (v[e] == 1'b0) e--;
		y = (v << (63 - e)) >> 32;
		frac = '0;
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 31;
			if (y >= 64'h1_0000_0000) begin
				y = y >> 1;
				frac = {frac[14:0], 1'b1};
			end else begin
				frac = {frac[14:0], 1'b0};
			end
		end
		lq = longint'(e - fbits) * 65536 + longint'(frac);
		r = ((lq * longint'(rma_pkg::DB_COEF) + (64'sd1 <<< 60) + (64'sd1 <<< 31)) >>> 32)
			- (64'sd1 <<< 28);
		if (r < rma_pkg::DB_MIN) r = rma_pkg::DB_MIN;
		if (r > rma_pkg::DB_MAX) r = rma_pkg::DB_MAX;
		return r[14:0];
	endfunction

	function automatic response_t predict_response(request_t it);
		response_t   o;
		logic [15:0] ant;
		logic [47:0] freq;
		int          slot, free_slot;
		logic [31:0] n;
		o = '{default: '0};
		ant = mdl_comb_ant ? 16'd0 : it.ant;
		freq = mdl_comb_freq ? 48'd0 : it.freq;
		if (it.op == rma_pkg::OP_CLEAR_ANT || it.op == rma_pkg::OP_CLEAR_ALL) begin
			for (int i = 0; i < rma_pkg::TABLE_ENTRIES; i++)
				if (tbl_valid[i] && (it.op == rma_pkg::OP_CLEAR_ALL || tbl_ant[i] == ant))
						begin
					tbl_valid[i] = 1'b0;
					o.removed++;
				end
			o.status = rma_pkg::STAT_CLEAR;
			return o;
		end
		slot = -1;
		free_slot = -1;
		for (int i = 0; i < rma_pkg::TABLE_ENTRIES; i++) begin
			if (tbl_valid[i]) begin
				if (slot < 0 && tbl_src[i] == it.src && tbl_ant[i] == ant &&
						tbl_freq[i] == freq)
					slot = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (slot >= 0) begin
			o.status = rma_pkg::STAT_UPDATED;
		end else if (free_slot >= 0) begin
			slot = free_slot;
			tbl_valid[slot] = 1'b1;
			tbl_src[slot] = it.src;
			tbl_ant[slot] = ant;
			tbl_freq[slot] = freq;
			tbl_count[slot] = '0;
			tbl_rx[slot] = '0;
			tbl_nf[slot] = '0;
			tbl_sinr[slot] = '0;
			tbl_inr[slot] = '0;
			o.status = rma_pkg::STAT_NEW;
		end else begin
			o.status = rma_pkg::STAT_FULL;
			return o;
		end
		n = tbl_count[slot];
		tbl_rx[slot] = mean_fold(tbl_rx[slot], n, it.rx);
		tbl_nf[slot] = mean_fold(tbl_nf[slot], n, it.nf);
		// zero divisors leave the old ratio in place
		if (tbl_nf[slot] != 0) tbl_sinr[slot] = ratio_q32(tbl_rx[slot], tbl_nf[slot]);
		if (it.sens != 0) tbl_inr[slot] = ratio_q32(tbl_nf[slot], it.sens);
		if (n != '1) tbl_count[slot] = n + 32'd1;
		o.count = tbl_count[slot];
		o.rx_db = db_of(tbl_rx[slot], 48);
		o.nf_db = db_of(tbl_nf[slot], 48);
		o.sinr_db = db_of(tbl_sinr[slot], 32);
		o.inr_db = db_of(tbl_inr[slot], 32);
		return o;
	endfunction

	function automatic void enqueue_req(request_t r);
		pending_q.insert(pending_q.size(), r);
	endfunction

	// --------------------------------------------------------------- driver
	request_t cur_req;
	int       burst_left = 0;
	int       gap_left = 0;

	always @(posedge clk) begin
		request_t  nxt;
		response_t exp_item;
		if (arst_n) begin
			if (req.valid && req.ready && cur_req.op != rma_pkg::OP_NONE) begin
				exp_item = predict_response(cur_req);
				expected_q.insert(expected_q.size(), exp_item);
			end
			if (!req.valid || req.ready) begin
				if (burst_left == 0 && gap_left > 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end
					burst_left--;
					nxt = pending_q.pop_front();
					cur_req = nxt;
					req.valid          <= 1'b1;
					req.operation      <= nxt.op;
					req.source_id      <= nxt.src;
					req.antenna_id     <= nxt.ant;
					req.frequency_hz   <= nxt.freq;
					req.rx_power_mw    <= nxt.rx;
					req.noise_floor_mw <= nxt.nf;
					req.sensitivity_mw <= nxt.sens;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// -------------------------------------------------------------- monitor
	int  stall_mode = 0;
	int  hold_left = 0;
	bit  held_once = 0;

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	// one long hold-off while the sender keeps offering requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (!held_once && phase_no == 2 && expected_q.size() > 0) begin
				held_once <= 1'b1;
				hold_left <= 6000;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	always @(posedge clk) begin
		response_t w;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$error("response with no request outstanding");
					err_cnt++;
				end else begin
					w = expected_q.pop_front();
					check_field("status", w.status, rsp.status);
					check_field("sample_count", w.count, rsp.sample_count);
					check_field("avg_rx_power_db", w.rx_db, rsp.avg_rx_power_db);
					check_field("avg_noise_floor_db", w.nf_db, rsp.avg_noise_floor_db);
					check_field("avg_sinr_db", w.sinr_db, rsp.avg_sinr_db);
					check_field("avg_inr_db", w.inr_db, rsp.avg_inr_db);
					check_field("entries_removed", w.removed, rsp.entries_removed);
				end
			end
			if (cyc % 97 == 0) stall_mode <= $urandom_range(0, 2);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= ($urandom_range(0, 3) != 0);
					default: rsp.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("[rf_receive_metric_averager] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------ stimulus
	function automatic logic [63:0] rand_level();
		logic [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(0, 15) == 0) return '0;
		if ($urandom_range(0, 15) == 0) return '1;
		return v >> $urandom_range(0, 63);
	endfunction

	function automatic request_t mk_req(logic [1:0] op, logic [15:0] src,
			logic [15:0] ant, logic [47:0] freq, logic [63:0] rx, logic [63:0] nf,
			logic [63:0] sens);
		request_t r;
		r.op = op; r.src = src; r.ant = ant; r.freq = freq;
		r.rx = rx; r.nf = nf; r.sens = sens;
		return r;
	endfunction

	function automatic request_t rand_req();
		request_t r;
		int       k;
		k = $urandom_range(0, 99);
		// mostly keys from a pool of 128 so entries repeat and the table fills
		if ($urandom_range(0, 9) == 0) begin
			r.src = 16'($urandom);
			r.ant = 16'($urandom);
			r.freq = 48'({$urandom, $urandom});
		end else begin
			r.src = 16'h1000 + 16'($urandom_range(0, 7));
			r.ant = 16'($urandom_range(0, 3));
			r.freq = 48'd2_400_000_000 + 48'd5_000_000 * 48'($urandom_range(0, 3));
		end
		r.rx = rand_level();
		r.nf = rand_level();
		r.sens = rand_level();
		if (k < 86) r.op = rma_pkg::OP_UPDATE;
		else if (k < 92) r.op = rma_pkg::OP_CLEAR_ANT;
		else if (k < 95) r.op = rma_pkg::OP_CLEAR_ALL;
		else r.op = rma_pkg::OP_NONE;
		return r;
	endfunction

	task automatic write_reg(logic idx, logic val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == rma_pkg::CFG_COMBINE_ANT) mdl_comb_ant = val;
		else mdl_comb_freq = val;
	endtask

	task automatic wait_drained();
		while (pending_q.size() > 0 || req.valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		logic [1:0] settings [5];
		// every input known from time zero
		req.valid = 1'b0;
		req.operation = rma_pkg::OP_NONE;
		req.source_id = '0;
		req.antenna_id = '0;
		req.frequency_hz = '0;
		req.rx_power_mw = '0;
		req.noise_floor_mw = '0;
		req.sensitivity_mw = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = rma_pkg::CFG_COMBINE_ANT;
		cfg.data = 1'b0;
		mdl_comb_ant = 1'b0;
		mdl_comb_freq = 1'b0;
		cur_req = mk_req(rma_pkg::OP_NONE, '0, '0, '0, '0, '0, '0);
		for (int i = 0; i < rma_pkg::TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(rma_pkg::CFG_COMBINE_ANT, 1'b0);
		write_reg(rma_pkg::CFG_COMBINE_FREQ, 1'b0);

		// directed: extremes, zero values and divisors, every operation
		enqueue_req(mk_req(rma_pkg::OP_UPDATE, '1, '1, '1, '1, '1, 64'd1));
		enqueue_req(mk_req(rma_pkg::OP_UPDATE, '1, '1, '1, '0, '0, '0));
		enqueue_req(mk_req(rma_pkg::OP_UPDATE, '1, '1, '1, 64'd1, '1, '1));
		enqueue_req(mk_req(rma_pkg::OP_UPDATE, '0, '0, '0, '0, '0, '0));
		enqueue_req(mk_req(rma_pkg::OP_UPDATE, '0, '0, '0, 64'd1 << 48, 64'd1, '0));
		enqueue_req(mk_req(rma_pkg::OP_UPDATE, 16'h5a5a, 16'd7, 48'hA5A5_5A5A_F00F,
			64'h0000_8000_0000_0000, 64'h0000_0000_1000_0000, 64'h0000_0001_0000_0000));
		enqueue_req(mk_req(rma_pkg::OP_NONE, 16'd1, 16'd7, 48'd1, '1, '1, '1));
		enqueue_req(mk_req(rma_pkg::OP_UPDATE, 16'h5a5a, 16'd7, 48'hA5A5_5A5A_F00F,
			64'd3, 64'd0, 64'd12345));
		enqueue_req(mk_req(rma_pkg::OP_CLEAR_ANT, '0, 16'd7, '0, '0, '0, '0));
		enqueue_req(mk_req(rma_pkg::OP_CLEAR_ANT, '0, 16'd7, '0, '0, '0, '0));
		enqueue_req(mk_req(rma_pkg::OP_UPDATE, 16'h0001, 16'd2, 48'd900_000_000,
			64'h0001_0000_0000_0000, 64'h0000_0010_0000_0000, 64'h0000_0001_0000_0000));
		enqueue_req(mk_req(rma_pkg::OP_CLEAR_ALL, '0, '0, '0, '0, '0, '0));
		enqueue_req(mk_req(rma_pkg::OP_CLEAR_ALL, '1, '1, '1, '1, '1, '1));
		wait_drained();

		settings = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b00};
		for (int p = 0; p < 5; p++) begin
			phase_no = p + 1;
			write_reg(rma_pkg::CFG_COMBINE_ANT, settings[p][0]);
			write_reg(rma_pkg::CFG_COMBINE_FREQ, settings[p][1]);
			for (int j = 0; j < 178; j++) enqueue_req(rand_req());
			// sender pauses here until every response is back
			wait_drained();
		end

		if (err_cnt == 0 && expected_q.size() == 0) begin
			$display("[rf_receive_metric_averager] OK");
		end else begin
			$display("[rf_receive_metric_averager] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
